[src/tilt_compass_octant_core_macros.svh]
// Assertion macros for the tilt-compensated compass core.
// Included by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef TILT_COMPASS_OCTANT_CORE_MACROS_SVH
`define TILT_COMPASS_OCTANT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TCO_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tco: same-cycle check failed");
`define TCO_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tco: next-cycle check failed");
`else
`define TCO_ASSERT_IMP(name, ante, cons)
`define TCO_ASSERT_NXT(name, ante, cons)
`endif
`endif

[src/tco_pkg.sv]
// Shared widths, constants and the arctangent table of the compass core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tco_pkg;
   localparam int SAMPLE_W     = 16;
   localparam int MUL_A_W      = 38;
   localparam int MUL_B_W      = 21;
   localparam int MUL_P_W      = 58;
   localparam int MUL_STEPS    = 20;
   localparam int SQRT_IN_W    = 40;
   localparam int ROOT_W       = 20;
   localparam int MAG_W        = 58;
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_STEPS = 16;
   localparam int ZACC_W       = 20;
   localparam int ANG_W        = 10;
   localparam int HEAD_W       = 11;
   localparam int QUARTER_TURN = 230400;
   localparam int HEAD_MAX     = 900;

   function automatic logic [ZACC_W-1:0] atan_entry(input logic [3:0] idx);
      logic [ZACC_W-1:0] val;
      case (idx)
         4'd0:    val = 20'd115200;
         4'd1:    val = 20'd68007;
         4'd2:    val = 20'd35933;
         4'd3:    val = 20'd18240;
         4'd4:    val = 20'd9155;
         4'd5:    val = 20'd4582;
         4'd6:    val = 20'd2292;
         4'd7:    val = 20'd1146;
         4'd8:    val = 20'd573;
         4'd9:    val = 20'd286;
         4'd10:   val = 20'd143;
         4'd11:   val = 20'd72;
         4'd12:   val = 20'd36;
         4'd13:   val = 20'd18;
         4'd14:   val = 20'd9;
         default: val = 20'd4;
      endcase
      return val;
   endfunction
endpackage
`default_nettype wire

[src/tco_mul.sv]
// Bit-serial signed multiplier: one multiplier bit is consumed per cycle.
// Depends on tco_pkg for its widths.
`timescale 1ns / 1ps
`default_nettype none
module tco_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tco_pkg::MUL_A_W-1:0]  a,
   input  logic signed [tco_pkg::MUL_B_W-1:0]  b,
   output logic                                done,
   output logic signed [tco_pkg::MUL_P_W-1:0]  prod
);
   logic [tco_pkg::MUL_A_W-1:0]   a_u, a_mag;
   logic [tco_pkg::MUL_B_W-1:0]   b_u, b_mag;
   logic [tco_pkg::MUL_P_W-1:0]   a_ff, a_in, acc_ff, acc_in;
   logic [tco_pkg::ROOT_W-1:0]    b_ff, b_in;
   logic                          neg_ff, neg_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   assign a_u   = a;
   assign b_u   = b;
   assign a_mag = a_u[tco_pkg::MUL_A_W-1] ? (~a_u + 38'd1) : a_u;
   assign b_mag = b_u[tco_pkg::MUL_B_W-1] ? (~b_u + 21'd1) : b_u;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = {20'd0, a_mag};
         b_in    = b_mag[tco_pkg::ROOT_W-1:0];
         acc_in  = '0;
         neg_in  = a_u[tco_pkg::MUL_A_W-1] ^ b_u[tco_pkg::MUL_B_W-1];
         cnt_in  = 5'(tco_pkg::MUL_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[tco_pkg::MUL_P_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[tco_pkg::ROOT_W-1:1]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign prod = neg_ff ? $signed(~acc_ff + 58'd1) : $signed(acc_ff);
endmodule
`default_nettype wire

[src/tco_sqrt.sv]
// Digit-serial floor square root: two radicand bits in, one root bit out per cycle.
// Depends on tco_pkg for its widths.
`timescale 1ns / 1ps
`default_nettype none
module tco_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [tco_pkg::SQRT_IN_W-1:0]      radicand,
   output logic                               done,
   output logic [tco_pkg::ROOT_W-1:0]         root
);
   logic [tco_pkg::SQRT_IN_W-1:0] n_ff, n_in;
   logic [21:0]                   rem_ff, rem_in, rem_sh, trial;
   logic [tco_pkg::ROOT_W-1:0]    res_ff, res_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          fits;

   assign rem_sh = {rem_ff[19:0], n_ff[tco_pkg::SQRT_IN_W-1 -: 2]};
   assign trial  = {res_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = radicand;
         rem_in  = '0;
         res_in  = '0;
         cnt_in  = 5'(tco_pkg::ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_sh - trial) : rem_sh;
         res_in = {res_ff[tco_pkg::ROOT_W-2:0], fits};
         n_in   = {n_ff[tco_pkg::SQRT_IN_W-3:0], 2'b00};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff;
endmodule
`default_nettype wire

[src/tco_cordic.sv]
// Arctangent unit: shift normalisation, then one CORDIC vectoring step per cycle.
// Depends on tco_pkg for widths and the angle table.
`timescale 1ns / 1ps
`default_nettype none
module tco_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tco_pkg::MAG_W-1:0]      u,
   input  logic [tco_pkg::MAG_W-1:0]      v,
   output logic                           done,
   output logic [tco_pkg::ANG_W-1:0]      angle
);
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_NORM = 2'd1;
   localparam logic [1:0] PH_ITER = 2'd2;
   localparam logic [1:0] PH_FIN  = 2'd3;

   logic [1:0]                           phase_ff, phase_in;
   logic [tco_pkg::MAG_W-1:0]            u_ff, u_in, v_ff, v_in, mx;
   logic signed [tco_pkg::CORDIC_W-1:0]  x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [tco_pkg::ZACC_W-1:0]    z_ff, z_in, tab;
   logic [3:0]                           i_ff, i_in;
   logic [tco_pkg::ANG_W-1:0]            ang_ff, ang_in;
   logic                                 done_ff, done_in;
   logic [17:0]                          zc;
   logic [18:0]                          zr;
   logic [10:0]                          zq;

   assign mx  = (u_ff > v_ff) ? u_ff : v_ff;
   assign dx  = x_ff >>> i_ff;
   assign dy  = y_ff >>> i_ff;
   assign tab = $signed(tco_pkg::atan_entry(i_ff));

   always_comb begin
      if (z_ff[tco_pkg::ZACC_W-1]) begin
         zc = '0;
      end else if (z_ff > 20'(tco_pkg::QUARTER_TURN)) begin
         zc = 18'(tco_pkg::QUARTER_TURN);
      end else begin
         zc = z_ff[17:0];
      end
      zr = {1'b0, zc} + 19'd128;
      zq = zr[18:8];
   end

   always_comb begin
      phase_in = phase_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      ang_in   = ang_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               u_in     = u;
               v_in     = v;
               phase_in = PH_NORM;
            end
         end
         PH_NORM: begin
            if (|mx[tco_pkg::MAG_W-1:30]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
            end else if (!mx[29]) begin
               u_in = u_ff << 1;
               v_in = v_ff << 1;
            end else begin
               x_in     = $signed({4'd0, u_ff[29:0]});
               y_in     = $signed({4'd0, v_ff[29:0]});
               z_in     = '0;
               i_in     = '0;
               phase_in = PH_ITER;
            end
         end
         PH_ITER: begin
            if (!y_ff[tco_pkg::CORDIC_W-1] && (y_ff != '0)) begin
               x_in = x_ff + dy;
               y_in = y_ff - dx;
               z_in = z_ff + tab;
            end else begin
               x_in = x_ff - dy;
               y_in = y_ff + dx;
               z_in = z_ff - tab;
            end
            i_in = i_ff + 4'd1;
            if (i_ff == 4'(tco_pkg::CORDIC_STEPS - 1)) begin
               phase_in = PH_FIN;
            end
         end
         PH_FIN: begin
            ang_in   = (zq > 11'(tco_pkg::HEAD_MAX)) ? 10'(tco_pkg::HEAD_MAX) : zq[9:0];
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
         i_ff     <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         i_ff     <= i_in;
      end
      u_ff   <= u_in;
      v_ff   <= v_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      ang_ff <= ang_in;
   end

   assign done  = done_ff;
   assign angle = ang_ff;
endmodule
`default_nettype wire

[src/tilt_compass_octant_core.sv]
// Top level of the tilt-compensated compass: sequencer, operand registers, octant choice.
// Depends on tco_pkg, tco_mul, tco_sqrt, tco_cordic and the assertion macro header.
//
// Channel | Direction | Beat contents (lowest bits first)
// req     | in        | accel_x, accel_y, accel_z, mag_x, mag_y, mag_z (16 bits each)
// rsp     | out       | led_index (3), led_lit (1), heading_tenths (11), one pad bit
//
// One sample is worked on at a time, by the bit-serial multiplier (twelve products),
// three square roots and the arctangent unit (up to 29 shifts, then 16 steps).
// A new sample is taken as soon as the previous result sits in the output register.
// Reset is synchronous and clears the sequencer, the lit LED and the output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "tilt_compass_octant_core_macros.svh"
module tilt_compass_octant_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // led_index, led_lit, heading_tenths, zero pad
   output logic [15:0] rsp_tdata
);
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL_GO   = 3'd1;
   localparam logic [2:0] S_MUL_WAIT = 3'd2;
   localparam logic [2:0] S_SQ_GO    = 3'd3;
   localparam logic [2:0] S_SQ_WAIT  = 3'd4;
   localparam logic [2:0] S_ANG      = 3'd5;
   localparam logic [2:0] S_ANG_WAIT = 3'd6;
   localparam logic [2:0] S_OUT      = 3'd7;

   localparam logic [3:0] OP_SXX = 4'd0;
   localparam logic [3:0] OP_SYY = 4'd1;
   localparam logic [3:0] OP_SZZ = 4'd2;
   localparam logic [3:0] OP_T1  = 4'd3;
   localparam logic [3:0] OP_T2  = 4'd4;
   localparam logic [3:0] OP_X   = 4'd5;
   localparam logic [3:0] OP_Y1  = 4'd6;
   localparam logic [3:0] OP_Y2  = 4'd7;
   localparam logic [3:0] OP_Y3  = 4'd8;
   localparam logic [3:0] OP_Y4  = 4'd9;
   localparam logic [3:0] OP_Y5  = 4'd10;
   localparam logic [3:0] OP_Y6  = 4'd11;

   localparam logic [1:0] SQ_P = 2'd0;
   localparam logic [1:0] SQ_Q = 2'd1;
   localparam logic [1:0] SQ_R = 2'd2;

   localparam logic signed [10:0] B_HI = 11'sd675;
   localparam logic signed [10:0] B_LO = 11'sd225;

   logic [2:0]                                state_ff, state_in;
   logic [3:0]                                op_ff, op_in;
   logic [1:0]                                sq_ff, sq_in;
   logic signed [tco_pkg::SAMPLE_W-1:0]       ax_ff, ay_ff, az_ff, mx_ff, my_ff, mz_ff;
   logic [31:0]                               sxx_ff, sxx_in, syy_ff, syy_in, szz_ff, szz_in;
   logic [tco_pkg::ROOT_W-1:0]                p_ff, p_in, q_ff, q_in, r_ff, r_in;
   logic signed [tco_pkg::MUL_P_W-1:0]        t1_ff, t1_in, w_ff, w_in, x_ff, x_in, y_ff, y_in;
   logic signed [tco_pkg::MUL_A_W-1:0]        tt_ff, tt_in;
   logic [tco_pkg::ANG_W-1:0]                 dmag_ff, dmag_in;
   logic [2:0]                                lit_oct_ff, lit_oct_in;
   logic                                      lit_valid_ff, lit_valid_in;
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]                               rsp_data_ff, rsp_data_in;

   logic signed [tco_pkg::MUL_A_W-1:0]        mul_a;
   logic signed [tco_pkg::MUL_B_W-1:0]        mul_b;
   logic signed [tco_pkg::MUL_P_W-1:0]        mul_prod;
   logic                                      mul_done;
   logic [31:0]                               sq_sum;
   logic [tco_pkg::ROOT_W-1:0]                sq_root;
   logic                                      sq_done;
   logic [tco_pkg::MAG_W-1:0]                 u_mag, v_mag;
   logic                                      cor_start, cor_done;
   logic [tco_pkg::ANG_W-1:0]                 cor_angle;
   logic signed [tco_pkg::HEAD_W-1:0]         d;
   logic                                      x_neg, x_pos, pick_ok;
   logic [2:0]                                pick;
   logic                                      req_fire;
   logic signed [tco_pkg::HEAD_W-1:0]         rsp_heading;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op_ff)
         OP_SXX: begin mul_a = 38'(ax_ff); mul_b = 21'(ax_ff); end
         OP_SYY: begin mul_a = 38'(ay_ff); mul_b = 21'(ay_ff); end
         OP_SZZ: begin mul_a = 38'(az_ff); mul_b = 21'(az_ff); end
         OP_T1:  begin mul_a = 38'(mx_ff); mul_b = $signed({1'b0, p_ff}); end
         OP_T2:  begin mul_a = 38'(mz_ff); mul_b = 21'(ax_ff); end
         OP_X:   begin mul_a = tt_ff; mul_b = $signed({1'b0, r_ff}); end
         OP_Y1:  begin mul_a = 38'(mx_ff); mul_b = 21'(ay_ff); end
         OP_Y2:  begin mul_a = w_ff[tco_pkg::MUL_A_W-1:0]; mul_b = 21'(ax_ff); end
         OP_Y3:  begin mul_a = 38'(my_ff); mul_b = $signed({1'b0, q_ff}); end
         OP_Y4:  begin mul_a = w_ff[tco_pkg::MUL_A_W-1:0]; mul_b = $signed({1'b0, r_ff}); end
         OP_Y5:  begin mul_a = 38'(mz_ff); mul_b = 21'(ay_ff); end
         OP_Y6:  begin mul_a = w_ff[tco_pkg::MUL_A_W-1:0]; mul_b = $signed({1'b0, p_ff}); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   tco_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_MUL_GO),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   always_comb begin
      unique case (sq_ff)
         SQ_P:    sq_sum = syy_ff + szz_ff;
         SQ_Q:    sq_sum = sxx_ff + szz_ff;
         default: sq_sum = sxx_ff + syy_ff + szz_ff;
      endcase
   end

   tco_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_SQ_GO),
      .radicand ({sq_sum, 8'd0}),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign u_mag     = x_ff[tco_pkg::MUL_P_W-1] ? 58'(-x_ff) : 58'(x_ff);
   assign v_mag     = y_ff[tco_pkg::MUL_P_W-1] ? 58'(-y_ff) : 58'(y_ff);
   assign cor_start = (state_ff == S_ANG) && (u_mag != '0) && (v_mag != '0);

   tco_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .u     (u_mag),
      .v     (v_mag),
      .done  (cor_done),
      .angle (cor_angle)
   );

   always_comb begin
      x_neg   = x_ff[tco_pkg::MUL_P_W-1];
      x_pos   = !x_neg && (x_ff != '0);
      d       = (x_neg ^ y_ff[tco_pkg::MUL_P_W-1]) ? -$signed({1'b0, dmag_ff})
                                                  : $signed({1'b0, dmag_ff});
      pick_ok = 1'b0;
      pick    = 3'd0;
      if (x_neg) begin
         pick_ok = 1'b1;
         if (d > B_HI) pick = 3'd3;
         else if (d > B_LO) pick = 3'd2;
         else if (d > 11'sd0) pick = 3'd1;
         else if (d == 11'sd0) pick_ok = 1'b0;
         else if (d >= -B_LO) pick = 3'd1;
         else if (d >= -B_HI) pick = 3'd0;
         else pick = 3'd7;
      end else if (x_pos) begin
         pick_ok = 1'b1;
         if (d > B_HI) pick = 3'd7;
         else if (d > B_LO) pick = 3'd6;
         else if (d > -B_LO) pick = 3'd5;
         else if (d == -B_LO) pick_ok = 1'b0;
         else if (d >= -B_HI) pick = 3'd4;
         else pick = 3'd3;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sq_in        = sq_ff;
      sxx_in       = sxx_ff;
      syy_in       = syy_ff;
      szz_in       = szz_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      t1_in        = t1_ff;
      tt_in        = tt_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dmag_in      = dmag_ff;
      lit_oct_in   = lit_oct_ff;
      lit_valid_in = lit_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = OP_SXX;
               sq_in    = SQ_P;
               state_in = S_MUL_GO;
            end
         end
         S_MUL_GO: state_in = S_MUL_WAIT;
         S_MUL_WAIT: begin
            if (mul_done) begin
               op_in    = op_ff + 4'd1;
               state_in = S_MUL_GO;
               case (op_ff)
                  OP_SXX: sxx_in = mul_prod[31:0];
                  OP_SYY: syy_in = mul_prod[31:0];
                  OP_SZZ: begin
                     szz_in   = mul_prod[31:0];
                     state_in = S_SQ_GO;
                  end
                  OP_T1:  t1_in = mul_prod;
                  OP_T2:  tt_in = 38'(t1_ff + (mul_prod <<< 4));
                  OP_X:   x_in = mul_prod;
                  OP_Y2:  y_in = mul_prod <<< 8;
                  OP_Y4:  y_in = y_ff + mul_prod;
                  OP_Y6: begin
                     y_in     = y_ff - (mul_prod <<< 4);
                     state_in = S_ANG;
                  end
                  default: w_in = mul_prod;
               endcase
            end
         end
         S_SQ_GO: state_in = S_SQ_WAIT;
         S_SQ_WAIT: begin
            if (sq_done) begin
               sq_in    = sq_ff + 2'd1;
               state_in = S_SQ_GO;
               case (sq_ff)
                  SQ_P: p_in = sq_root;
                  SQ_Q: q_in = sq_root;
                  default: begin
                     r_in     = sq_root;
                     state_in = S_MUL_GO;
                  end
               endcase
            end
         end
         S_ANG: begin
            if (v_mag == '0) begin
               dmag_in  = '0;
               state_in = S_OUT;
            end else if (u_mag == '0) begin
               dmag_in  = 10'(tco_pkg::HEAD_MAX);
               state_in = S_OUT;
            end else begin
               state_in = S_ANG_WAIT;
            end
         end
         S_ANG_WAIT: begin
            if (cor_done) begin
               dmag_in  = cor_angle;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (pick_ok) begin
                  lit_oct_in   = pick;
                  lit_valid_in = 1'b1;
               end
               rsp_data_in  = {1'b0, d, (pick_ok | lit_valid_ff),
                               (pick_ok ? pick : lit_oct_ff)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_SXX;
         sq_ff        <= SQ_P;
         lit_oct_ff   <= '0;
         lit_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         sq_ff        <= sq_in;
         lit_oct_ff   <= lit_oct_in;
         lit_valid_ff <= lit_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
         mx_ff <= req_tdata[63:48];
         my_ff <= req_tdata[79:64];
         mz_ff <= req_tdata[95:80];
      end
      sxx_ff      <= sxx_in;
      syy_ff      <= syy_in;
      szz_ff      <= szz_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      t1_ff       <= t1_in;
      tt_ff       <= tt_in;
      w_ff        <= w_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      dmag_ff     <= dmag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign rsp_heading = rsp_tdata[14:4];

   `TCO_ASSERT_NXT(a_busy_after_accept, req_fire, state_ff != S_IDLE)
   `TCO_ASSERT_NXT(a_lit_sticky, lit_valid_ff, lit_valid_ff)
   `TCO_ASSERT_IMP(a_unlit_reads_zero, rsp_tvalid && !rsp_tdata[3], rsp_tdata[2:0] == 3'd0)
   `TCO_ASSERT_IMP(a_heading_range, rsp_tvalid, (rsp_heading <= 11'sd900) && (rsp_heading >= -11'sd900))
endmodule
`default_nettype wire

[verif/tilt_compass_octant_checker.sv]
// Checker for the compass core: predicts each result beat from the accepted sample beats
// and compares it, field by field, with what the block returns. Depends on nothing else.
`timescale 1ns / 1ps
module tilt_compass_octant_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic signed [10:0] heading;
      logic               led_lit;
      logic [2:0]         led_index;
   } compass_result_type;

   compass_result_type heading_queue[$];
   logic [2:0] lit_octant;
   logic       lit_valid;

   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic int angle_tenths(input longint unsigned u, input longint unsigned v);
      longint unsigned big;
      longint          x;
      longint          y;
      longint          dx;
      longint          dy;
      int              z;
      int              step_atan[16];
      step_atan = '{115200, 68007, 35933, 18240, 9155, 4582, 2292, 1146,
                    573, 286, 143, 72, 36, 18, 9, 4};
      z   = 0;
      big = (u > v) ? u : v;
      while (big >= (64'd1 << 30)) begin
         u = u >> 1;  v = v >> 1;  big = big >> 1;
      end
      while (big < (64'd1 << 29)) begin
         u = u << 1;  v = v << 1;  big = big << 1;
      end
      x = longint'(u);
      y = longint'(v);
      for (int i = 0; i < 16; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x = x + dy;  y = y - dx;  z = z + step_atan[i];
         end else begin
            x = x - dy;  y = y + dx;  z = z - step_atan[i];
         end
      end
      if (z < 0) z = 0;
      if (z > 230400) z = 230400;
      z = (z + 128) >>> 8;
      if (z > 900) z = 900;
      return z;
   endfunction

   always @(posedge clock) begin
      compass_result_type want;
      compass_result_type got;
      longint ax, ay, az, mx, my, mz, p, q, r, xh, yh;
      longint unsigned u, v;
      int dd;
      int pick;
      if (reset) begin
         lit_octant <= '0;
         lit_valid  <= 1'b0;
         heading_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[14:0];
            if (heading_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected result beat %h at %0t", rsp_tdata, $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = heading_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("Mismatch: led_index %0d/%0d led_lit %0d/%0d heading %0d/%0d",
                              want.led_index, got.led_index, want.led_lit, got.led_lit,
                              want.heading, got.heading);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            ax = longint'($signed(req_tdata[15:0]));
            ay = longint'($signed(req_tdata[31:16]));
            az = longint'($signed(req_tdata[47:32]));
            mx = longint'($signed(req_tdata[63:48]));
            my = longint'($signed(req_tdata[79:64]));
            mz = longint'($signed(req_tdata[95:80]));
            p  = longint'(floor_root(longint'(ay * ay + az * az) << 8));
            q  = longint'(floor_root(longint'(ax * ax + az * az) << 8));
            r  = longint'(floor_root(longint'(ax * ax + ay * ay + az * az) << 8));
            xh = r * (mx * p + 16 * mz * ax);
            yh = 256 * mx * ay * ax + my * q * r - 16 * mz * ay * p;
            u  = (xh < 0) ? longint'(-xh) : xh;
            v  = (yh < 0) ? longint'(-yh) : yh;
            if (v == 0) dd = 0;
            else if (u == 0) dd = 900;
            else dd = angle_tenths(u, v);
            if ((xh < 0) != (yh < 0)) dd = -dd;
            pick = -1;
            if (xh < 0) begin
               if (dd > 675) pick = 3;
               else if (dd > 225) pick = 2;
               else if (dd > 0) pick = 1;
               else if (dd == 0) pick = -1;
               else if (dd >= -225) pick = 1;
               else if (dd >= -675) pick = 0;
               else pick = 7;
            end else if (xh > 0) begin
               if (dd > 675) pick = 7;
               else if (dd > 225) pick = 6;
               else if (dd > -225) pick = 5;
               else if (dd == -225) pick = -1;
               else if (dd >= -675) pick = 4;
               else pick = 3;
            end
            want.led_index = lit_octant;
            want.led_lit   = lit_valid;
            if (pick >= 0) begin
               want.led_index = pick[2:0];
               want.led_lit   = 1'b1;
               lit_octant    <= pick[2:0];
               lit_valid     <= 1'b1;
            end
            want.heading = dd[10:0];
            heading_queue.push_back(want);
         end
      end
      pending = heading_queue.size();
   end
endmodule

[verif/tilt_compass_octant_core_tb.sv]
// Top of the compass core testbench: clock, reset, sample and result-side stimulus, verdict.
// Depends on tilt_compass_octant_core and tilt_compass_octant_checker.
`timescale 1ns / 1ps
module tilt_compass_octant_core_tb;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          cycle_count;
   logic        quiet;
   int          stall_left;

   tilt_compass_octant_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   tilt_compass_octant_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(input logic [15:0] ax, ay, az, mx, my, mz);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mz, my, mx, az, ay, ax};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [15:0] near_axis();
      return 16'($signed($urandom_range(0, 4000)) - 2000);
   endfunction

   initial begin
      logic [15:0] g;
      cycle_count = 0;
      quiet       = 1'b0;
      stall_left  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Zero accelerometer: no LED chosen yet, so index and lit stay clear.
      send_sample(0, 0, 0, 16'd1000, 16'd1000, 16'd1000);
      send_sample(0, 0, 0, 0, 0, 0);
      // Flat board, field turned through the eight directions, then off-axis and near-boundary ones.
      send_sample(0, 0, 16'd16384, 16'd1000, 0, 0);
      send_sample(0, 0, 16'd16384, 16'd1000, 16'd1000, 0);
      send_sample(0, 0, 16'd16384, 0, 16'd1000, 0);
      send_sample(0, 0, 16'd16384, -16'sd1000, 16'd1000, 0);
      send_sample(0, 0, 16'd16384, -16'sd1000, 0, 0);
      send_sample(0, 0, 16'd16384, -16'sd1000, -16'sd1000, 0);
      send_sample(0, 0, 16'd16384, 0, -16'sd1000, 0);
      send_sample(0, 0, 16'd16384, 16'd1000, -16'sd1000, 0);
      send_sample(0, 0, 16'd16384, 16'd1000, -16'sd5000, 0);
      send_sample(0, 0, 16'd16384, -16'sd1000, -16'sd5000, 0);
      send_sample(0, 0, 16'd16384, 16'd10000, -16'sd4142, 0);
      send_sample(0, 0, 16'd16384, -16'sd10000, 16'd1, 0);
      // Extremes of every field, then small and mixed values.
      send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_sample(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001);
      send_sample(16'h7fff, 0, 0, 0, 16'h7fff, 16'h8000);
      for (int n = 0; n < 1250; n++) begin
         if (n >= 1100) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0, 1, 2: send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom));
            3:       send_sample(0, 0, 0, 16'($urandom), 16'($urandom), 16'($urandom));
            4:       send_sample(near_axis(), near_axis(), 16'd16384, 16'($urandom), 0,
                                 near_axis());
            default: begin
               g = ($urandom_range(0, 1) == 1) ? 16'd16384 : -16'sd16384;
               send_sample(near_axis(), near_axis(), g,
                           16'($urandom_range(0, 8000)) - 16'd4000,
                           16'($urandom_range(0, 8000)) - 16'd4000, near_axis());
            end
         endcase
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
